### src/voxel_row_face_merger_assert.svh
// Assertion macros shared by the checker of the voxel row face merger.
// No dependencies; included by the checker file.
`ifndef VOXEL_ROW_FACE_MERGER_ASSERT_SVH
`define VOXEL_ROW_FACE_MERGER_ASSERT_SVH

// Implication checked in the same cycle, switched off while reset is held.
`define VRFM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrfm check failed");

// Implication checked in the next cycle, switched off while reset is held.
`define VRFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrfm check failed");

// Implication checked in the next cycle, also during reset.
`define VRFM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vrfm check failed");

`endif

### src/vrfm_pkg.sv
// Package of the voxel row face merger: item types, face codes and constants.
// No dependencies; used by every module of the block.
package vrfm_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         lower_type;
        logic [7:0]         lower_meta;
        logic               lower_opaque;
        logic [7:0]         lower_light;
        logic [7:0]         upper_type;
        logic [7:0]         upper_meta;
        logic               upper_opaque;
        logic [7:0]         upper_light;
        logic               row_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic [7:0]         shade;
        logic [2:0]         facing;
        logic               quad_last;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] axis_mode;
        logic [7:0] air_type;
    } t_cfg;

    typedef struct packed {
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [15:0] base_z;
        logic [2:0]  face;
        logic [7:0]  shade;
        logic [7:0]  count;
    } t_job;

    typedef struct packed {
        t_job job0;
        t_job job1;
        logic two;
    } t_entry;

    localparam logic [2:0] FACE_WEST   = 3'd0;
    localparam logic [2:0] FACE_EAST   = 3'd1;
    localparam logic [2:0] FACE_SOUTH  = 3'd2;
    localparam logic [2:0] FACE_NORTH  = 3'd3;
    localparam logic [2:0] FACE_BOTTOM = 3'd4;
    localparam logic [2:0] FACE_TOP    = 3'd5;

    localparam logic CFG_AXIS_MODE = 1'b0;
    localparam logic CFG_AIR_TYPE  = 1'b1;

    localparam int MAX_ROW_DEFAULT     = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

endpackage

### src/vrfm_front.sv
// Front part of the voxel row face merger: run merging and boundary classification.
// Depends on vrfm_pkg; feeds vrfm_queue.
module vrfm_front
    import vrfm_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_entry   o_q_data
);

    localparam int unsigned SHADE_DIV = 160;
    localparam int unsigned MUL_EW  = (1989 * 65536 + SHADE_DIV / 2) / SHADE_DIV;
    localparam int unsigned MUL_NS  = (1428 * 65536 + SHADE_DIV / 2) / SHADE_DIV;
    localparam int unsigned MUL_BOT = (867 * 65536 + SHADE_DIV / 2) / SHADE_DIV;
    localparam int unsigned MUL_TOP = (2550 * 65536 + SHADE_DIV / 2) / SHADE_DIV;

    typedef struct packed {
        logic [7:0] lt;
        logic [7:0] lm;
        logic       lo;
        logic [4:0] ll;
        logic [7:0] ut;
        logic [7:0] um;
        logic       uo;
        logic [4:0] ul;
    } t_pair;

    function automatic logic [20:0] shade_mul(input logic [2:0] face);
        logic [20:0] m;
        unique case (face)
            FACE_WEST, FACE_EAST:   m = 21'(MUL_EW);
            FACE_SOUTH, FACE_NORTH: m = 21'(MUL_NS);
            FACE_BOTTOM:            m = 21'(MUL_BOT);
            default:                m = 21'(MUL_TOP);
        endcase
        return m;
    endfunction

    function automatic logic visible(input t_pair p, input logic [7:0] air);
        return !((p.lt == air) && (p.ut == air)) && !(p.lo && p.uo);
    endfunction

    function automatic t_job make_job(input t_pair p, input t_cfg c,
                                      input logic [15:0] ox, input logic [15:0] oy,
                                      input logic [15:0] oz, input logic [7:0] cnt);
        t_job        j;
        logic        up;
        logic [4:0]  light;
        logic [25:0] prod;
        up = (p.lt != c.air_type) && (p.ut == c.air_type);
        j.base_x = ox;
        j.base_y = oy;
        j.base_z = oz;
        j.count  = cnt;
        unique case (c.axis_mode)
            2'd1:    j.face = up ? FACE_EAST : FACE_WEST;
            2'd2:    j.face = up ? FACE_TOP : FACE_BOTTOM;
            default: j.face = up ? FACE_NORTH : FACE_SOUTH;
        endcase
        if (!up) begin
            unique case (c.axis_mode)
                2'd1:    j.base_x = ox + 16'd1;
                2'd2:    j.base_z = oz + 16'd1;
                default: j.base_y = oy + 16'd1;
            endcase
        end
        light   = up ? p.ul : p.ll;
        prod    = 26'(light) * 26'(shade_mul(j.face));
        j.shade = prod[23:16];
        return j;
    endfunction

    function automatic logic [4:0] clamp_light(input logic [7:0] l);
        return (l > 8'd16) ? 5'd16 : l[4:0];
    endfunction

    logic        r_held_valid;
    t_pair       r_held_pair;
    logic [15:0] r_org_x, r_org_y, r_org_z;
    logic [7:0]  r_count;

    t_pair       pair;
    logic        accept, close_a, extend, vis_a, vis_b;
    logic [15:0] n_org_x, n_org_y, n_org_z;
    logic [7:0]  n_count;
    t_job        job_a, job_b;

    always_comb begin
        pair.lt = i_item.lower_type;
        pair.lm = i_item.lower_meta;
        pair.lo = i_item.lower_opaque;
        pair.ll = clamp_light(i_item.lower_light);
        pair.ut = i_item.upper_type;
        pair.um = i_item.upper_meta;
        pair.uo = i_item.upper_opaque;
        pair.ul = clamp_light(i_item.upper_light);

        accept  = i_push && !i_q_full;
        close_a = r_held_valid &&
                  ((r_held_pair.lt != pair.lt) || (r_held_pair.lm != pair.lm) ||
                   (r_held_pair.ut != pair.ut) || (r_held_pair.um != pair.um) ||
                   (r_count >= 8'(MAX_ROW)));
        extend  = r_held_valid && !close_a;
        n_org_x = extend ? r_org_x : i_item.pos_x;
        n_org_y = extend ? r_org_y : i_item.pos_y;
        n_org_z = extend ? r_org_z : i_item.pos_z;
        n_count = extend ? r_count + 8'd1 : 8'd1;

        job_a = make_job(r_held_pair, i_cfg, r_org_x, r_org_y, r_org_z, r_count);
        job_b = make_job(pair, i_cfg, n_org_x, n_org_y, n_org_z, n_count);
        vis_a = close_a && visible(r_held_pair, i_cfg.air_type);
        vis_b = i_item.row_end && visible(pair, i_cfg.air_type);

        o_q_push      = accept && (vis_a || vis_b);
        o_q_data.job0 = vis_a ? job_a : job_b;
        o_q_data.job1 = job_b;
        o_q_data.two  = vis_a && vis_b;
        o_full        = i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_pair  <= '0;
            r_org_x      <= '0;
            r_org_y      <= '0;
            r_org_z      <= '0;
            r_count      <= '0;
        end else if (accept) begin
            r_held_valid <= !i_item.row_end;
            r_held_pair  <= pair;
            r_org_x      <= n_org_x;
            r_org_y      <= n_org_y;
            r_org_z      <= n_org_z;
            r_count      <= i_item.row_end ? 8'd0 : n_count;
        end
    end

endmodule

### src/vrfm_queue.sv
// Short queue of face jobs between the front and back parts of the merger.
// Depends on vrfm_pkg.
module vrfm_queue
    import vrfm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### src/vrfm_back.sv
// Back part of the voxel row face merger: expands face jobs into quad vertices.
// Depends on vrfm_pkg; drains vrfm_queue.
module vrfm_back
    import vrfm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_entry  i_q_data,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    // Vertex offsets of one face, three bits {z,y,x} per vertex, vertex 0 lowest.
    function automatic logic [11:0] face_offsets(input logic [2:0] face);
        logic [11:0] r;
        unique case (face)
            FACE_WEST:   r = 12'b110_010_000_100;
            FACE_EAST:   r = 12'b011_111_101_001;
            FACE_SOUTH:  r = 12'b000_001_101_100;
            FACE_NORTH:  r = 12'b110_111_011_010;
            FACE_BOTTOM: r = 12'b010_011_001_000;
            default:     r = 12'b111_110_100_101;
        endcase
        return r;
    endfunction

    logic        r_out_valid;
    t_result     r_out;
    logic [2:0]  r_beat;

    t_job        job;
    logic [1:0]  vert;
    logic [11:0] offs;
    logic [2:0]  off;
    logic        along_z, load, final_beat;
    logic [15:0] run_len;
    t_result     n_out;

    always_comb begin
        job        = r_beat[2] ? i_q_data.job1 : i_q_data.job0;
        vert       = r_beat[1:0];
        offs       = face_offsets(job.face);
        off        = offs[3*vert +: 3];
        along_z    = (job.face == FACE_WEST) || (job.face == FACE_EAST);
        run_len    = {8'd0, job.count};
        final_beat = (vert == 2'd3) && (r_beat[2] || !i_q_data.two);
        load       = !i_q_empty && (!r_out_valid || i_pop);
        o_q_pop    = load && final_beat;

        n_out.vertex_x  = job.base_x + (off[0] ? (along_z ? 16'd1 : run_len) : 16'd0);
        n_out.vertex_y  = job.base_y + (off[1] ? 16'd1 : 16'd0);
        n_out.vertex_z  = job.base_z + (off[2] ? (along_z ? run_len : 16'd1) : 16'd0);
        n_out.shade     = job.shade;
        n_out.facing    = job.face;
        n_out.quad_last = (vert == 2'd3);
        n_out.last      = final_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= '0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_beat      <= final_beat ? 3'd0 : r_beat + 3'd1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

### src/voxel_row_face_merger.sv
// Voxel row face merger: one voxel pair per item in, quad vertices out. An item is accepted
// while the job queue has room; a closed run with a visible face gives four results and
// an item that closes two such runs gives eight, delivered at one result per cycle by the
// vertex stage while the output is popped. An item that closes no run with a visible face
// gives no result at all.
// Depends on vrfm_pkg, vrfm_front, vrfm_queue and vrfm_back.
module voxel_row_face_merger
    import vrfm_pkg::*;
#(
    parameter int MAX_ROW     = MAX_ROW_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    t_cfg   r_cfg;
    logic   q_push, q_full, q_pop, q_empty;
    t_entry q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AXIS_MODE: r_cfg.axis_mode <= i_cfg_data[1:0];
                default:       r_cfg.air_type  <= i_cfg_data;
            endcase
        end
    end

    vrfm_front #(.MAX_ROW(MAX_ROW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    vrfm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    vrfm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

### src/vrfm_checker.sv
// Port-level checks of the voxel row face merger, bound to the top level.
// Depends on vrfm_pkg and voxel_row_face_merger_assert.svh.
`include "voxel_row_face_merger_assert.svh"

module vrfm_port_checker
    import vrfm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    `VRFM_ASSERT_NEXT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n, empty)
    `VRFM_ASSERT_SAME(a_last_ends_quad, i_clk, i_rst_n,
                      !empty && o_result.last, o_result.quad_last)
    `VRFM_ASSERT_NEXT(a_quad_continues, i_clk, i_rst_n,
                      !empty && pop && !o_result.quad_last,
                      !empty && $stable(o_result.facing))
    `VRFM_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
                      !empty && !pop, !empty && $stable(o_result))

endmodule

bind voxel_row_face_merger vrfm_port_checker u_vrfm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
